### rtl/ptt_pkg.sv
// Shared constants, codes and control types for the periodic task timer table.
`default_nettype none
package ptt_pkg;

   localparam int SLOTS   = 16;
   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int COUNT_W = 5;
   localparam int TICK_W  = 10;
   localparam int TIME_W  = 32;
   localparam int RSLOT_W = 8;

   localparam logic [RSLOT_W-1:0] NONE_SLOT = 8'hFF;

   typedef enum logic [2:0] {
      FN_TICK     = 3'd0,
      FN_REGISTER = 3'd1,
      FN_DELETE   = 3'd2,
      FN_ENABLE   = 3'd3,
      FN_PROCESS  = 3'd4,
      FN_EXECUTE  = 3'd5,
      FN_QUERY    = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      SS_UNINIT  = 2'd0,
      SS_READY   = 2'd1,
      SS_PENDING = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      CS_IDLE  = 2'd0,
      CS_EXEC  = 2'd1,
      CS_SCAN  = 2'd2,
      CS_CLOSE = 2'd3
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
      logic scan_adv;
      logic close;
   } ptt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      func_type func;
      logic     out_free;
      logic     scan_due;
      logic     scan_last;
   } ptt_stat_type;

endpackage
`default_nettype wire

### rtl/ptt_if.sv
// Valid/ready channel interfaces for command beats and result beats.
`default_nettype none
interface ptt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [7:0]  slot;
   logic [31:0] interval;
   logic [31:0] first_delay;
   logic        enable;

   modport source (output valid, func, slot, interval, first_delay, enable, input ready);
   modport sink   (input valid, func, slot, interval, first_delay, enable, output ready);
endinterface

interface ptt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] result_slot;
   logic       ok;
   logic       fired;
   logic [1:0] status;
   logic [4:0] active_count;
   logic       last;

   modport source (output valid, result_slot, ok, fired, status, active_count, last,
                   input ready);
   modport sink   (input valid, result_slot, ok, fired, status, active_count, last,
                   output ready);
endinterface
`default_nettype wire

### rtl/periodic_task_timer_table_unit.sv
// Periodic task timer table: a 16-slot table of periodic tasks over a 32-bit wrapping time base.
// Commands arrive as beats on req_chan (func, slot, interval, first_delay, enable) and every
// result leaves as a beat on rsp_chan; both channels use valid/ready and a beat moves when
// both are high. csr_wr_en with csr_wr_data writes the tick step and may only be used while
// the block is idle.
// One command is handled at a time. A tick, register, delete, enable, execute or query command
// beat, or one with an unused code, is taken in the idle state and its single result is loaded
// into the output register from the execute state once that register is free. A process command
// walks the slot table one slot per cycle while not stalled, through a single due-time compare
// unit, giving one fire beat per due slot followed by a closing beat with last set.
// The result sits in an output register, so a new command can be taken while the previous
// result waits. When the receiver holds ready low, a pending result stalls the controller:
// the scan pauses on a due slot until its fire beat can be loaded.
// Reset (synchronous, active high) clears time, the occupancy, enable and state bits and the
// occupied count, and sets the tick step to 1; no clearing pass is needed.
`default_nettype none
module periodic_task_timer_table_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [9:0] csr_wr_data,
   ptt_req_if.sink         req_chan,
   ptt_rsp_if.source       rsp_chan
);
   import ptt_pkg::*;

   ptt_cmd_type  cmd;
   ptt_stat_type stat;

   ptt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ptt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_func         (req_chan.func),
      .req_slot         (req_chan.slot),
      .req_interval     (req_chan.interval),
      .req_first_delay  (req_chan.first_delay),
      .req_enable       (req_chan.enable),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_result_slot  (rsp_chan.result_slot),
      .rsp_ok           (rsp_chan.ok),
      .rsp_fired        (rsp_chan.fired),
      .rsp_status       (rsp_chan.status),
      .rsp_active_count (rsp_chan.active_count),
      .rsp_last         (rsp_chan.last),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule
`default_nettype wire

### rtl/ptt_ctrl.sv
// Controller state machine that sequences one command at a time.
`default_nettype none
module ptt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire ptt_pkg::ptt_stat_type stat,
   output ptt_pkg::ptt_cmd_type       cmd
);
   import ptt_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               state_in = (stat.func == FN_PROCESS) ? CS_SCAN : CS_EXEC;
            end
         end
         CS_EXEC: begin
            if (stat.out_free) begin
               state_in = CS_IDLE;
            end
         end
         CS_SCAN: begin
            if ((!stat.scan_due || stat.out_free) && stat.scan_last) begin
               state_in = CS_CLOSE;
            end
         end
         CS_CLOSE: begin
            if (stat.out_free) begin
               state_in = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         CS_EXEC:  cmd.exec = stat.out_free;
         // A due slot holds the scan until the output register can take its fire beat.
         CS_SCAN:  cmd.scan_adv = !stat.scan_due || stat.out_free;
         CS_CLOSE: cmd.close = stat.out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/ptt_dp.sv
// Datapath: time counter, slot table, scan counter and the result register.
`default_nettype none
module ptt_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [9:0]             csr_wr_data,
   input  wire logic [2:0]             req_func,
   input  wire logic [7:0]             req_slot,
   input  wire logic [31:0]            req_interval,
   input  wire logic [31:0]            req_first_delay,
   input  wire logic                   req_enable,
   input  wire logic                   rsp_ready,
   output logic                        rsp_valid,
   output logic [7:0]                  rsp_result_slot,
   output logic                        rsp_ok,
   output logic                        rsp_fired,
   output logic [1:0]                  rsp_status,
   output logic [4:0]                  rsp_active_count,
   output logic                        rsp_last,
   input  wire ptt_pkg::ptt_cmd_type   cmd,
   output ptt_pkg::ptt_stat_type       stat
);
   import ptt_pkg::*;

   // Configuration and time.
   logic [TICK_W-1:0]  tick_step_ff;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SLOT_W-1:0]  cnt_ff, cnt_in;

   // Slot table.
   logic [SLOTS-1:0]   used_ff, used_in;
   logic [SLOTS-1:0]   enabled_ff, enabled_in;
   slot_state_type     state_ff [SLOTS];
   slot_state_type     state_in [SLOTS];
   logic [TIME_W-1:0]  interval_ff [SLOTS];
   logic [TIME_W-1:0]  delay_ff [SLOTS];
   logic [TIME_W-1:0]  last_ff [SLOTS];

   // Latched command.
   func_type           func_ff;
   logic [7:0]         slot_ff;
   logic [TIME_W-1:0]  ivl_ff;
   logic [TIME_W-1:0]  dly_ff;
   logic               en_ff;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rslot_ff, rslot_in;
   logic               ok_ff, ok_in;
   logic               fired_ff, fired_in;
   logic [1:0]         status_ff, status_in;
   logic [COUNT_W-1:0] acount_ff;
   logic               last_bit_ff, last_bit_in;
   logic               rsp_load;

   // Table update controls.
   logic               wr_cfg, wr_fire, wr_pend, wr_del, wr_en;
   logic [SLOT_W-1:0]  wr_idx;

   logic [SLOT_W-1:0]  slot_idx;
   logic               live;
   logic               free_found;
   logic [SLOT_W-1:0]  free_idx;
   logic [TIME_W-1:0]  elapsed;
   logic [TIME_W-1:0]  limit;
   logic               scan_active;
   logic               scan_due;
   logic               out_free;

   assign slot_idx = slot_ff[SLOT_W-1:0];
   assign live     = (slot_ff < 8'(SLOTS)) && used_ff[slot_idx];
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // Due test of the slot under the scan counter.
   assign elapsed     = now_ff - last_ff[cnt_ff];
   assign limit       = (delay_ff[cnt_ff] != '0) ? delay_ff[cnt_ff] : interval_ff[cnt_ff];
   assign scan_active = used_ff[cnt_ff] && enabled_ff[cnt_ff];
   assign scan_due    = scan_active && (elapsed >= limit);

   assign stat.func      = (cmd.load) ? func_type'(req_func) : func_ff;
   assign stat.out_free  = out_free;
   assign stat.scan_due  = scan_due;
   assign stat.scan_last = (cnt_ff == SLOT_W'(SLOTS - 1));

   always_comb begin
      now_in      = now_ff;
      count_in    = count_ff;
      wr_cfg      = 1'b0;
      wr_fire     = 1'b0;
      wr_pend     = 1'b0;
      wr_del      = 1'b0;
      wr_en       = 1'b0;
      wr_idx      = slot_idx;
      rsp_load    = 1'b0;
      rslot_in    = NONE_SLOT;
      ok_in       = 1'b0;
      fired_in    = 1'b0;
      status_in   = SS_UNINIT;
      last_bit_in = 1'b1;
      priority if (cmd.exec) begin
         rsp_load = 1'b1;
         unique case (func_ff)
            FN_TICK: begin
               now_in = now_ff + TIME_W'(tick_step_ff);
               ok_in  = 1'b1;
            end
            FN_REGISTER: begin
               if (free_found) begin
                  wr_cfg   = 1'b1;
                  wr_idx   = free_idx;
                  count_in = count_ff + 1'b1;
                  rslot_in = RSLOT_W'(free_idx);
                  ok_in    = 1'b1;
               end
            end
            FN_DELETE: begin
               wr_del   = live;
               count_in = live ? count_ff - 1'b1 : count_ff;
               rslot_in = slot_ff;
               ok_in    = live;
            end
            FN_ENABLE: begin
               wr_en    = live;
               rslot_in = slot_ff;
               ok_in    = live;
            end
            FN_EXECUTE: begin
               wr_fire  = live && enabled_ff[slot_idx];
               rslot_in = slot_ff;
               ok_in    = live && enabled_ff[slot_idx];
               fired_in = live && enabled_ff[slot_idx];
            end
            FN_QUERY: begin
               rslot_in  = slot_ff;
               ok_in     = live;
               status_in = live ? state_ff[slot_idx] : SS_UNINIT;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end else if (cmd.scan_adv) begin
         wr_idx = cnt_ff;
         if (scan_due) begin
            wr_fire     = 1'b1;
            rsp_load    = 1'b1;
            rslot_in    = RSLOT_W'(cnt_ff);
            ok_in       = 1'b1;
            fired_in    = 1'b1;
            last_bit_in = 1'b0;
         end else begin
            wr_pend = scan_active;
         end
      end else if (cmd.close) begin
         rsp_load = 1'b1;
         ok_in    = 1'b1;
      end
   end

   always_comb begin
      used_in    = used_ff;
      enabled_in = enabled_ff;
      state_in   = state_ff;
      if (wr_cfg) begin
         used_in[wr_idx]    = 1'b1;
         enabled_in[wr_idx] = en_ff;
         state_in[wr_idx]   = en_ff ? SS_READY : SS_PENDING;
      end
      if (wr_del) begin
         used_in[wr_idx]  = 1'b0;
         state_in[wr_idx] = SS_UNINIT;
      end
      if (wr_en) begin
         enabled_in[wr_idx] = en_ff;
         state_in[wr_idx]   = en_ff ? SS_READY : SS_PENDING;
      end
      if (wr_fire) begin
         state_in[wr_idx] = SS_READY;
      end
      if (wr_pend) begin
         state_in[wr_idx] = SS_PENDING;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load) begin
         cnt_in = '0;
      end else if (cmd.scan_adv) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_step_ff <= TICK_W'(1);
         now_ff       <= '0;
         count_ff     <= '0;
         cnt_ff       <= '0;
         used_ff      <= '0;
         enabled_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            state_ff[i] <= SS_UNINIT;
         end
      end else begin
         if (csr_wr_en) begin
            tick_step_ff <= csr_wr_data;
         end
         now_ff       <= now_in;
         count_ff     <= count_in;
         cnt_ff       <= cnt_in;
         used_ff      <= used_in;
         enabled_ff   <= enabled_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Slot timing words and the latched command carry no reset.
   always_ff @(posedge clock) begin
      if (wr_cfg) begin
         interval_ff[wr_idx] <= ivl_ff;
         delay_ff[wr_idx]    <= dly_ff;
         last_ff[wr_idx]     <= now_ff;
      end
      if (wr_fire) begin
         delay_ff[wr_idx] <= '0;
         last_ff[wr_idx]  <= now_ff;
      end
      if (cmd.load) begin
         func_ff <= func_type'(req_func);
         slot_ff <= req_slot;
         ivl_ff  <= req_interval;
         dly_ff  <= req_first_delay;
         en_ff   <= req_enable;
      end
      if (rsp_load) begin
         rslot_ff    <= rslot_in;
         ok_ff       <= ok_in;
         fired_ff    <= fired_in;
         status_ff   <= status_in;
         acount_ff   <= count_in;
         last_bit_ff <= last_bit_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_slot  = rslot_ff;
   assign rsp_ok           = ok_ff;
   assign rsp_fired        = fired_ff;
   assign rsp_status       = status_ff;
   assign rsp_active_count = acount_ff;
   assign rsp_last         = last_bit_ff;

   // The occupied count always agrees with the occupancy bits.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == COUNT_W'($countones(used_ff)))
      else $error("occupied count disagrees with slot occupancy");

   // A tick advances time by exactly the configured step.
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && func_ff == FN_TICK) |=>
         now_ff == $past(now_ff) + TIME_W'($past(tick_step_ff)))
      else $error("tick did not advance time by the step");

   // A fire beat only ever comes from an occupied, enabled slot.
   a_fire_enabled: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && fired_in) |-> (used_ff[wr_idx] && enabled_ff[wr_idx]))
      else $error("fire beat from a free or disabled slot");

   // A result is never loaded over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result register overwritten while stalled");

endmodule
`default_nettype wire

### tb/periodic_task_timer_table_unit_tb.sv
// Self-checking testbench for the periodic task timer table: directed table, then random phases.
`default_nettype none
module periodic_task_timer_table_unit_tb;
   import ptt_pkg::*;

   localparam logic [2:0] FN_UNUSED   = 3'd7;
   localparam int         LIMIT       = 800000;
   localparam int         SETTLE      = 24;
   localparam int         HOLD_CYCLES = 300;
   localparam int         PHASES      = 6;
   localparam int         PHASE_ITEMS = 80;

   typedef struct packed {
      logic [2:0]  func;
      logic [7:0]  slot;
      logic [31:0] period;
      logic [31:0] delay;
      logic        en;
   } cmd_t;

   typedef struct packed {
      logic [7:0] rslot;
      logic       ok;
      logic       fired;
      logic [1:0] status;
      logic [4:0] count;
      logic       last;
   } beat_t;

   typedef struct packed {
      cmd_t  cmd;
      logic  typed;
      beat_t want;
   } row_t;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [9:0] csr_wr_data;

   ptt_req_if req_chan();
   ptt_rsp_if rsp_chan();

   periodic_task_timer_table_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   // Our own copy of the timer table.
   bit [9:0]       step_m;
   bit [31:0]      now_m;
   bit             used_m [SLOTS];
   bit             en_m [SLOTS];
   bit [31:0]      period_m [SLOTS];
   bit [31:0]      delay_m [SLOTS];
   bit [31:0]      last_tick_m [SLOTS];
   slot_state_type state_m [SLOTS];
   bit [4:0]       count_m;

   beat_t table_beats [$];
   beat_t timer_results_q [$];
   row_t  directed_rows [$];

   int send_idle_pct = 7;
   int recv_idle_pct = 85;
   int cmds_taken    = 0;
   int mismatches    = 0;
   int cycle_count   = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic beat_t make_beat(input logic [7:0] rslot, input logic ok,
                                       input logic fired, input logic [1:0] status,
                                       input logic last);
      beat_t b;
      b.rslot  = rslot;
      b.ok     = ok;
      b.fired  = fired;
      b.status = status;
      b.count  = count_m;
      b.last   = last;
      return b;
   endfunction

   task automatic reset_timer_table();
      step_m  = 10'd1;
      now_m   = '0;
      count_m = '0;
      for (int i = 0; i < SLOTS; i++) begin
         used_m[i]      = 1'b0;
         en_m[i]        = 1'b0;
         period_m[i]    = '0;
         delay_m[i]     = '0;
         last_tick_m[i] = '0;
         state_m[i]     = SS_UNINIT;
      end
   endtask

   // Applies one command to the table copy and leaves its results in table_beats.
   task automatic run_timer_table(input cmd_t c);
      logic [SLOT_W-1:0] idx;
      logic              live;
      logic              due;
      logic [31:0]       elapsed;
      logic              placed;
      idx  = c.slot[SLOT_W-1:0];
      live = (c.slot < SLOTS) && used_m[idx];
      table_beats.delete();
      case (c.func)
         FN_TICK: begin
            now_m = now_m + {22'd0, step_m};
            table_beats.push_back(make_beat(NONE_SLOT, 1'b1, 1'b0, SS_UNINIT, 1'b1));
         end
         FN_REGISTER: begin
            placed = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
               if (!placed && !used_m[i]) begin
                  placed         = 1'b1;
                  used_m[i]      = 1'b1;
                  en_m[i]        = c.en;
                  period_m[i]    = c.period;
                  delay_m[i]     = c.delay;
                  last_tick_m[i] = now_m;
                  state_m[i]     = c.en ? SS_READY : SS_PENDING;
                  count_m        = count_m + 5'd1;
                  table_beats.push_back(make_beat(i[7:0], 1'b1, 1'b0, SS_UNINIT, 1'b1));
               end
            end
            if (!placed)
               table_beats.push_back(make_beat(NONE_SLOT, 1'b0, 1'b0, SS_UNINIT, 1'b1));
         end
         FN_DELETE: begin
            if (live) begin
               used_m[idx]  = 1'b0;
               state_m[idx] = SS_UNINIT;
               count_m      = count_m - 5'd1;
            end
            table_beats.push_back(make_beat(c.slot, live, 1'b0, SS_UNINIT, 1'b1));
         end
         FN_ENABLE: begin
            if (live) begin
               en_m[idx]    = c.en;
               state_m[idx] = c.en ? SS_READY : SS_PENDING;
            end
            table_beats.push_back(make_beat(c.slot, live, 1'b0, SS_UNINIT, 1'b1));
         end
         FN_PROCESS: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (used_m[i] && en_m[i]) begin
                  elapsed = now_m - last_tick_m[i];
                  due = (delay_m[i] != 0) ? (elapsed >= delay_m[i]) : (elapsed >= period_m[i]);
                  if (due) begin
                     last_tick_m[i] = now_m;
                     delay_m[i]     = '0;
                     state_m[i]     = SS_READY;
                     table_beats.push_back(make_beat(i[7:0], 1'b1, 1'b1, SS_UNINIT, 1'b0));
                  end else begin
                     state_m[i] = SS_PENDING;
                  end
               end
            end
            table_beats.push_back(make_beat(NONE_SLOT, 1'b1, 1'b0, SS_UNINIT, 1'b1));
         end
         FN_EXECUTE: begin
            if (live && en_m[idx]) begin
               last_tick_m[idx] = now_m;
               delay_m[idx]     = '0;
               state_m[idx]     = SS_READY;
               table_beats.push_back(make_beat(c.slot, 1'b1, 1'b1, SS_UNINIT, 1'b1));
            end else begin
               table_beats.push_back(make_beat(c.slot, 1'b0, 1'b0, SS_UNINIT, 1'b1));
            end
         end
         FN_QUERY: begin
            table_beats.push_back(make_beat(c.slot, live, 1'b0,
                                            live ? state_m[idx] : SS_UNINIT, 1'b1));
         end
         default: begin
            table_beats.push_back(make_beat(NONE_SLOT, 1'b0, 1'b0, SS_UNINIT, 1'b1));
         end
      endcase
   endtask

   function automatic cmd_t random_cmd(input int reg_pct);
      cmd_t c;
      int   pick;
      int   scale;
      scale = 4 * int'(step_m) + 8;
      pick  = $urandom_range(99);
      if (pick < reg_pct) begin
         c.func = FN_REGISTER;
      end else begin
         pick = $urandom_range(99);
         if (pick < 22)      c.func = FN_TICK;
         else if (pick < 40) c.func = FN_PROCESS;
         else if (pick < 55) c.func = FN_DELETE;
         else if (pick < 68) c.func = FN_ENABLE;
         else if (pick < 80) c.func = FN_EXECUTE;
         else if (pick < 97) c.func = FN_QUERY;
         else                c.func = FN_UNUSED;
      end
      pick = $urandom_range(99);
      if (pick < 85)      c.slot = 8'($urandom_range(0, SLOTS - 1));
      else if (pick < 96) c.slot = 8'($urandom_range(0, 255));
      else                c.slot = (pick < 98) ? NONE_SLOT : 8'(SLOTS);
      pick = $urandom_range(99);
      if (pick < 60)      c.period = $urandom_range(0, scale);
      else if (pick < 80) c.period = $urandom_range(0, 5000);
      else                c.period = $urandom;
      pick = $urandom_range(99);
      if (pick < 45)      c.delay = '0;
      else if (pick < 85) c.delay = $urandom_range(1, scale);
      else                c.delay = $urandom;
      c.en = ($urandom_range(99) < 80);
      return c;
   endfunction

   task automatic add_row(input logic [2:0] func, input logic [7:0] slot,
                          input logic [31:0] period, input logic [31:0] delay,
                          input logic en, input logic typed, input logic [7:0] rslot,
                          input logic ok, input logic fired, input logic [1:0] status,
                          input logic [4:0] count);
      row_t r;
      r.cmd.func       = func;
      r.cmd.slot       = slot;
      r.cmd.period     = period;
      r.cmd.delay      = delay;
      r.cmd.en         = en;
      r.typed          = typed;
      r.want.rslot     = rslot;
      r.want.ok        = ok;
      r.want.fired     = fired;
      r.want.status    = status;
      r.want.count     = count;
      r.want.last      = 1'b1;
      directed_rows.push_back(r);
   endtask

   // Called right after a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_cmd(input cmd_t c, input logic typed, input beat_t want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.func        = c.func;
      req_chan.slot        = c.slot;
      req_chan.interval    = c.period;
      req_chan.first_delay = c.delay;
      req_chan.enable      = c.en;
      req_chan.valid       = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      run_timer_table(c);
      if (typed) begin
         timer_results_q.push_back(want);
      end else begin
         foreach (table_beats[k]) timer_results_q.push_back(table_beats[k]);
      end
      cmds_taken++;
      @(negedge clock);
   endtask

   // The sender stays quiet until every outstanding result has been seen.
   task automatic drain_results();
      req_chan.valid = 1'b0;
      while (timer_results_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_step(input logic [9:0] value);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      step_m      = value;
   endtask

   // Receiver: random ready, plus two long hold-offs so the block backs up into its input.
   initial begin
      int hold_left;
      int holds_done;
      int hold_at;
      hold_left  = 0;
      holds_done = 0;
      hold_at    = 150;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left == 0 && holds_done < 2 && cmds_taken >= hold_at) begin
            hold_left  = HOLD_CYCLES;
            holds_done = holds_done + 1;
            hold_at    = 420;
         end
         if (hold_left > 0) begin
            hold_left      = hold_left - 1;
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      beat_t got;
      beat_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.rslot  = rsp_chan.result_slot;
         got.ok     = rsp_chan.ok;
         got.fired  = rsp_chan.fired;
         got.status = rsp_chan.status;
         got.count  = rsp_chan.active_count;
         got.last   = rsp_chan.last;
         if (timer_results_q.size() == 0) begin
            $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
            mismatches++;
         end else begin
            want = timer_results_q.pop_front();
            if (got.rslot !== want.rslot) begin
               $display("%0t: result_slot expected %0d actual %0d", $time, want.rslot,
                        got.rslot);
               mismatches++;
            end
            if (got.ok !== want.ok) begin
               $display("%0t: ok expected %0d actual %0d", $time, want.ok, got.ok);
               mismatches++;
            end
            if (got.fired !== want.fired) begin
               $display("%0t: fired expected %0d actual %0d", $time, want.fired, got.fired);
               mismatches++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        got.status);
               mismatches++;
            end
            if (got.count !== want.count) begin
               $display("%0t: active_count expected %0d actual %0d", $time, want.count,
                        got.count);
               mismatches++;
            end
            if (got.last !== want.last) begin
               $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [9:0] phase_step [PHASES];
      beat_t      no_beat;
      no_beat              = '0;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_chan.valid       = 1'b0;
      req_chan.func        = FN_TICK;
      req_chan.slot        = '0;
      req_chan.interval    = '0;
      req_chan.first_delay = '0;
      req_chan.enable      = 1'b0;
      reset_timer_table();

      phase_step[0] = 10'd1000;
      phase_step[1] = 10'd0;
      phase_step[2] = 10'd1023;
      phase_step[3] = 10'($urandom_range(1, 1000));
      phase_step[4] = 10'd1;
      phase_step[5] = 10'($urandom_range(2, 999));

      // Empty table, out-of-range and free slots, unused code, then a few live tasks.
      add_row(FN_QUERY,    8'd0,   0, 0, 0, 1, 8'd0,   0, 0, SS_UNINIT, 5'd0);
      add_row(FN_DELETE,   8'd255, 0, 0, 0, 1, 8'd255, 0, 0, SS_UNINIT, 5'd0);
      add_row(FN_EXECUTE,  8'd3,   0, 0, 1, 1, 8'd3,   0, 0, SS_UNINIT, 5'd0);
      add_row(FN_ENABLE,   8'd16,  0, 0, 1, 1, 8'd16,  0, 0, SS_UNINIT, 5'd0);
      add_row(FN_PROCESS,  8'd0,   0, 0, 0, 1, NONE_SLOT, 1, 0, SS_UNINIT, 5'd0);
      add_row(FN_TICK,     8'd0,   0, 0, 0, 1, NONE_SLOT, 1, 0, SS_UNINIT, 5'd0);
      add_row(FN_UNUSED,   8'd5,   0, 0, 1, 1, NONE_SLOT, 0, 0, SS_UNINIT, 5'd0);
      add_row(FN_REGISTER, 8'd0, 32'hFFFF_FFFF, 0, 1, 1, 8'd0, 1, 0, SS_UNINIT, 5'd1);
      add_row(FN_REGISTER, 8'd0, 0, 0, 1, 1, 8'd1, 1, 0, SS_UNINIT, 5'd2);
      add_row(FN_REGISTER, 8'd0, 5, 32'hFFFF_FFFF, 1, 1, 8'd2, 1, 0, SS_UNINIT, 5'd3);
      add_row(FN_REGISTER, 8'd0, 3, 2, 0, 1, 8'd3, 1, 0, SS_UNINIT, 5'd4);
      add_row(FN_QUERY,    8'd3,   0, 0, 0, 1, 8'd3,   1, 0, SS_PENDING, 5'd4);
      add_row(FN_PROCESS,  8'd0,   0, 0, 0, 0, 8'd0,   0, 0, SS_UNINIT, 5'd0);
      add_row(FN_QUERY,    8'd0,   0, 0, 0, 0, 8'd0,   0, 0, SS_UNINIT, 5'd0);
      add_row(FN_EXECUTE,  8'd3,   0, 0, 0, 1, 8'd3,   0, 0, SS_UNINIT, 5'd4);
      add_row(FN_ENABLE,   8'd3,   0, 0, 1, 1, 8'd3,   1, 0, SS_UNINIT, 5'd4);
      add_row(FN_TICK,     8'd0,   0, 0, 0, 0, 8'd0,   0, 0, SS_UNINIT, 5'd0);
      add_row(FN_TICK,     8'd0,   0, 0, 0, 0, 8'd0,   0, 0, SS_UNINIT, 5'd0);
      add_row(FN_PROCESS,  8'd0,   0, 0, 0, 0, 8'd0,   0, 0, SS_UNINIT, 5'd0);
      add_row(FN_EXECUTE,  8'd2,   0, 0, 0, 1, 8'd2,   1, 1, SS_UNINIT, 5'd4);
      add_row(FN_QUERY,    8'd2,   0, 0, 0, 0, 8'd0,   0, 0, SS_UNINIT, 5'd0);
      add_row(FN_DELETE,   8'd1,   0, 0, 0, 1, 8'd1,   1, 0, SS_UNINIT, 5'd3);
      add_row(FN_ENABLE,   8'd15,  0, 0, 0, 1, 8'd15,  0, 0, SS_UNINIT, 5'd3);
      add_row(FN_REGISTER, 8'd0,   7, 0, 0, 0, 8'd0,   0, 0, SS_UNINIT, 5'd0);
      add_row(FN_PROCESS,  8'd0,   0, 0, 0, 0, 8'd0,   0, 0, SS_UNINIT, 5'd0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[r])
         send_cmd(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].want);

      for (int p = 0; p < PHASES; p++) begin
         drain_results();
         write_step(phase_step[p]);
         if (p < 2) begin
            send_idle_pct = 7;
            recv_idle_pct = 85;
         end else if (p < 4) begin
            send_idle_pct = 85;
            recv_idle_pct = 7;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // Alternate between filling the table up and letting deletes thin it out.
         for (int k = 0; k < PHASE_ITEMS; k++)
            send_cmd(random_cmd((p % 2 == 0) ? 35 : 15), 1'b0, no_beat);
      end

      drain_results();
      if (mismatches == 0 && timer_results_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

### files.f
rtl/ptt_pkg.sv
rtl/ptt_if.sv
rtl/ptt_ctrl.sv
rtl/ptt_dp.sv
rtl/periodic_task_timer_table_unit.sv
tb/periodic_task_timer_table_unit_tb.sv
